>>> rtl/deq_pkg.sv
// shared types and constants for the double-ended queue
// no dependencies; used by the interfaces and every module of the block

package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int CMD_WIDTH          = 3;
   localparam int STATUS_WIDTH       = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5
   } command_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // per-word information that travels alongside the memory read
   typedef struct packed {
      logic       is_read;
      status_type status;
   } item_info_type;

endpackage

>>> rtl/deq_ifs.sv
// valid/ready channel interfaces for the request and response words
// depends on deq_pkg for field widths

interface deq_req_if #(
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
);
   logic                                  valid;
   logic                                  ready;
   logic [deq_pkg::CMD_WIDTH-1:0]         command;
   logic signed [DATA_WIDTH-1:0]          value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface deq_rsp_if #(
   parameter int DATA_WIDTH  = deq_pkg::DATA_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = $clog2(deq_pkg::DEPTH_DEFAULT + 1)
);
   logic                                  valid;
   logic                                  ready;
   logic signed [DATA_WIDTH-1:0]          data;
   logic [deq_pkg::STATUS_WIDTH-1:0]      status;
   logic [COUNT_WIDTH-1:0]                fill_count;
   logic                                  deque_empty;

   modport source (output valid, output data, output status, output fill_count,
                   output deque_empty, input ready);
   modport sink   (input valid, input data, input status, input fill_count,
                   input deque_empty, output ready);
endinterface

>>> rtl/double_ended_queue.sv
// Double-ended queue of signed words held in a ring buffer of DEPTH slots.
// req_bus carries one word per command: push front, push back, pop front,
// pop back, peek front or peek back, with the value to push. rsp_bus returns
// exactly one word per command, in order: the data popped or peeked (zero for
// pushes and errors), a status (ok, empty, or full on push), the fill count
// after the command and an empty flag.
// rsp_bus.valid rises when the output register loads: the slot ram is read at the
// accepting edge (pointers update there too, so the next command sees them at
// once); the output register loads from the ram stage when empty or draining.
// Throughput is one command per cycle while rsp_bus.ready stays high; the
// single-port slot ram with its registered read sets this figure.
// When the receiver stalls, the output register holds its word and one more
// command can still be taken into the ram stage; after that req_bus.ready
// drops until the output drains. Nothing is lost or reordered.
// Reset (synchronous) empties the deque and drops any word in flight; the
// slot contents are left as they are and never read before being written.
// depends on deq_pkg, deq_ifs, deq_ram and deq_ctrl

module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   deq_req_if.sink       req_bus,
   deq_rsp_if.source     rsp_bus
);
   import deq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                  accept;
   logic                  mem_wr_en, mem_rd_en;
   logic [AW-1:0]         mem_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;
   item_info_type         ctrl_info;
   logic [CW-1:0]         ctrl_count;

   logic                  s1_valid_ff, s1_valid_in;
   item_info_type         s1_info_ff;
   logic [CW-1:0]         s1_count_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_data_ff;
   status_type            out_status_ff;
   logic [CW-1:0]         out_count_ff;
   logic                  out_empty_ff;
   logic                  out_load;

   assign out_load      = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || out_load;
   assign accept        = req_bus.valid && req_bus.ready;

   deq_ctrl #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_bus.command),
      .value       (req_bus.value),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .info        (ctrl_info),
      .fill_count  (ctrl_count)
   );

   deq_ram #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff  <= ctrl_info;
         s1_count_ff <= ctrl_count;
      end
      if (out_load) begin
         out_data_ff   <= s1_info_ff.is_read ? mem_rd_data : '0;
         out_status_ff <= s1_info_ff.status;
         out_count_ff  <= s1_count_ff;
         out_empty_ff  <= (s1_count_ff == '0);
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.data        = out_data_ff;
   assign rsp_bus.status      = out_status_ff;
   assign rsp_bus.fill_count  = out_count_ff;
   assign rsp_bus.deque_empty = out_empty_ff;

`ifndef ASSERT_OFF
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |=> s1_valid_ff && $stable(s1_info_ff))
      else $error("ram stage word lost while output stalled");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_load) |-> !accept)
      else $error("command taken over an undelivered word");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_empty_ff == (out_count_ff == '0)))
      else $error("empty flag disagrees with fill count");
`endif

endmodule

>>> rtl/deq_ram.sv
// slot storage: single-port synchronous ram with registered read data
// depends on deq_pkg for default sizes

module deq_ram #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   output logic [DATA_WIDTH-1:0]        rd_data
);
   import deq_pkg::*;

   logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[addr] <= wr_data;
      end
   end

   // read register only moves on a read, so it holds while the output stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/deq_ctrl.sv
// pointer and occupancy control: decodes each command into at most one ram access
// depends on deq_pkg for command and status codes

module deq_ctrl #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [deq_pkg::CMD_WIDTH-1:0]     command,
   input  logic [DATA_WIDTH-1:0]             value,
   output logic                              mem_wr_en,
   output logic                              mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]          mem_addr,
   output logic [DATA_WIDTH-1:0]             mem_wr_data,
   output deq_pkg::item_info_type            info,
   output logic [$clog2(DEPTH+1)-1:0]        fill_count
);
   import deq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [AW-1:0] head_next, head_prev, tail_next, tail_prev;
   logic          is_full, no_words;

   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
   assign tail_prev = (tail_ff == '0) ? LAST_SLOT : tail_ff - 1'b1;
   assign is_full   = (occ_ff == FULL_COUNT);
   assign no_words  = (occ_ff == '0);

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_addr     = head_ff;
      mem_wr_data  = value;
      info.is_read = 1'b0;
      info.status  = ST_OK;
      if (accept) begin
         case (command)
            CMD_PUSH_FRONT: begin
               if (is_full) begin
                  info.status = ST_FULL;
               end else begin
                  head_in   = head_prev;
                  mem_addr  = head_prev;
                  mem_wr_en = 1'b1;
                  occ_in    = occ_ff + CW'(1);
               end
            end
            CMD_PUSH_BACK: begin
               if (is_full) begin
                  info.status = ST_FULL;
               end else begin
                  tail_in   = tail_next;
                  mem_addr  = tail_ff;
                  mem_wr_en = 1'b1;
                  occ_in    = occ_ff + CW'(1);
               end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
               if (no_words) begin
                  info.status = ST_EMPTY;
               end else begin
                  mem_addr     = head_ff;
                  mem_rd_en    = 1'b1;
                  info.is_read = 1'b1;
                  if (command == CMD_POP_FRONT) begin
                     head_in = head_next;
                     occ_in  = occ_ff - CW'(1);
                  end
               end
            end
            CMD_POP_BACK, CMD_PEEK_BACK: begin
               if (no_words) begin
                  info.status = ST_EMPTY;
               end else begin
                  mem_addr     = tail_prev;
                  mem_rd_en    = 1'b1;
                  info.is_read = 1'b1;
                  if (command == CMD_POP_BACK) begin
                     tail_in = tail_prev;
                     occ_in  = occ_ff - CW'(1);
                  end
               end
            end
            default: begin
               // unused codes leave the state alone and report ok
            end
         endcase
      end
   end

   assign fill_count = occ_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

`ifndef ASSERT_OFF
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_COUNT)
      else $error("occupancy above depth");

   a_ptrs_meet: assert property (@(posedge clock) disable iff (reset)
      (no_words || is_full) |-> (head_ff == tail_ff))
      else $error("pointers apart while empty or full");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (accept && is_full && (command == CMD_PUSH_FRONT || command == CMD_PUSH_BACK))
      |=> $stable(occ_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("push into full deque changed state");

   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("read and write in one cycle");
`endif

endmodule

>>> sim/tb_top.sv
// self-checking bench for double_ended_queue: directed corner words, then biased random
// fill and drain bursts checked word by word against an in-bench ring buffer predictor
// depends on deq_pkg, deq_ifs and the double_ended_queue rtl

module tb_top;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int WORD_BITS   = 32;
   localparam int RANDOM_ITEMS = 1500;
   localparam int DRAIN_CYCLES = 8;

   // command codes the block treats as no-ops
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_SPARE_B = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  command;
      logic [WORD_BITS-1:0]  value;
   } deque_request_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]  data;
      status_type            status;
      logic [4:0]            fill_count;
      logic                  deque_empty;
   } deque_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   deque_request_type  request_backlog[$];
   deque_response_type expected_responses[$];

   // predictor state
   logic [WORD_BITS-1:0] ring_words [QUEUE_DEPTH] = '{default: '0};
   logic [3:0]           front_slot = '0;
   logic [3:0]           back_slot = '0;
   logic [4:0]           words_held = '0;

   int error_count = 0;
   int cycle_no = 0;
   int hold_left = 0;

   // no idling on either side inside this window
   function automatic logic calm_window();
      return (cycle_no >= 1200 && cycle_no < 1700);
   endfunction

   function automatic deque_response_type predict_deque(deque_request_type req);
      deque_response_type rsp;
      rsp.data   = '0;
      rsp.status = ST_OK;
      case (req.command)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (words_held == 5'(QUEUE_DEPTH)) begin
               rsp.status = ST_FULL;
            end else if (req.command == CMD_PUSH_FRONT) begin
               front_slot = front_slot - 4'd1;
               ring_words[front_slot] = req.value;
               words_held = words_held + 5'd1;
            end else begin
               ring_words[back_slot] = req.value;
               back_slot = back_slot + 4'd1;
               words_held = words_held + 5'd1;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
            if (words_held == 5'd0) begin
               rsp.status = ST_EMPTY;
            end else if (req.command == CMD_POP_FRONT) begin
               rsp.data = ring_words[front_slot];
               front_slot = front_slot + 4'd1;
               words_held = words_held - 5'd1;
            end else if (req.command == CMD_POP_BACK) begin
               back_slot = back_slot - 4'd1;
               rsp.data = ring_words[back_slot];
               words_held = words_held - 5'd1;
            end else if (req.command == CMD_PEEK_FRONT) begin
               rsp.data = ring_words[front_slot];
            end else begin
               rsp.data = ring_words[back_slot - 4'd1];
            end
         end
         default: begin
         end
      endcase
      rsp.fill_count  = words_held;
      rsp.deque_empty = (words_held == 5'd0);
      return rsp;
   endfunction

   function automatic logic [WORD_BITS-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_WIDTH-1:0] pick_command(traffic_mix_type mix);
      int roll;
      int push_share;
      roll = $urandom_range(0, 99);
      push_share = (mix == MIX_FILL) ? 78 : (mix == MIX_DRAIN) ? 25 : 50;
      if (roll < 3)
         return $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      if (roll < 3 + push_share)
         return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      case ($urandom_range(0, 3))
         0: return CMD_POP_FRONT;
         1: return CMD_POP_BACK;
         2: return CMD_PEEK_FRONT;
         default: return CMD_PEEK_BACK;
      endcase
   endfunction

   task automatic queue_request(logic [CMD_WIDTH-1:0] command, logic [WORD_BITS-1:0] value);
      deque_request_type req;
      req.command = command;
      req.value   = value;
      request_backlog = {request_backlog, req};
   endtask

   task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset)
         cycle_no <= cycle_no + 1;
   end

   // request driver
   always @(posedge clock) begin
      deque_request_type req;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.command <= '0;
         req_bus.value   <= '0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (request_backlog.size() != 0 &&
             (calm_window() || $urandom_range(0, 99) >= 20)) begin
            req = request_backlog[0];
            request_backlog.delete(0);
            req_bus.valid   <= 1'b1;
            req_bus.command <= req.command;
            req_bus.value   <= req.value;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response receiver, with long hold-offs to back the block up
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (cycle_no == 300 || cycle_no == 2100) begin
         hold_left     <= 60;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm_window() || ($urandom_range(0, 99) >= 20);
      end
   end

   // monitor: check returned words, then predict for the word accepted at this edge
   always @(posedge clock) begin
      deque_response_type want;
      deque_request_type  taken;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response word, data %h status %0d count %0d",
                        $time, rsp_bus.data, rsp_bus.status, rsp_bus.fill_count);
               error_count++;
            end else begin
               want = expected_responses[0];
               expected_responses.delete(0);
               if (rsp_bus.data !== want.data)
                  report_mismatch("data", want.data, rsp_bus.data);
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", want.status, rsp_bus.status);
               if (rsp_bus.fill_count !== want.fill_count)
                  report_mismatch("fill_count", want.fill_count, rsp_bus.fill_count);
               if (rsp_bus.deque_empty !== want.deque_empty)
                  report_mismatch("deque_empty", want.deque_empty, rsp_bus.deque_empty);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.command = req_bus.command;
            taken.value   = req_bus.value;
            expected_responses = {expected_responses, predict_deque(taken)};
         end
      end
   end

   initial begin
      traffic_mix_type mix;
      int burst_len;
      int made;
      logic [CMD_WIDTH-1:0] command;

      // empty deque: every read is refused, spare codes do nothing
      queue_request(CMD_POP_FRONT, 32'h1234_5678);
      queue_request(CMD_POP_BACK, 32'h0);
      queue_request(CMD_PEEK_FRONT, 32'hffff_ffff);
      queue_request(CMD_PEEK_BACK, 32'h0);
      queue_request(CMD_SPARE_A, 32'h7fff_ffff);
      queue_request(CMD_SPARE_B, 32'h8000_0000);
      // extreme words at both ends
      queue_request(CMD_PUSH_FRONT, 32'h8000_0000);
      queue_request(CMD_PUSH_BACK, 32'h7fff_ffff);
      queue_request(CMD_PEEK_FRONT, 32'h0);
      queue_request(CMD_PEEK_BACK, 32'h0);
      queue_request(CMD_PUSH_FRONT, 32'hffff_ffff);
      queue_request(CMD_PUSH_BACK, 32'h0000_0000);
      queue_request(CMD_SPARE_B, 32'h5555_5555);
      queue_request(CMD_POP_FRONT, 32'h0);
      queue_request(CMD_POP_BACK, 32'h0);
      queue_request(CMD_POP_BACK, 32'h0);
      queue_request(CMD_POP_FRONT, 32'h0);
      queue_request(CMD_POP_FRONT, 32'h0);
      queue_request(CMD_PEEK_BACK, 32'haaaa_aaaa);

      // random bursts that swing the deque between empty and full
      made = 0;
      while (made < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: mix = MIX_FILL;
            1: mix = MIX_DRAIN;
            default: mix = MIX_EVEN;
         endcase
         burst_len = $urandom_range(8, 48);
         for (int i = 0; i < burst_len; i++) begin
            command = pick_command(mix);
            queue_request(command, pick_word());
            made++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || req_bus.valid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_responses.size() != 0)
         $display("%0t: %0d expected response words never arrived",
                  $time, expected_responses.size());
      if (error_count == 0 && expected_responses.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
